// ===== rtl/frame_bitmap_allocator_defines.svh =====
// Assertion macros for the frame allocator
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fba_pkg.sv =====
package fba_pkg;

  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = 6;
  localparam int FRAME_W        = 12;
  localparam int CNT_W          = 13;
  localparam int NUM_FRAMES_DEF = 4096;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 24;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = CNT_W'(NUM_FRAMES_DEF);

  typedef struct packed {
    logic               kind;
    logic [FRAME_W-1:0] current_frame;
    logic               kernel_page;
    logic               writable;
  } req_t;

  typedef struct packed {
    logic               entry_written;
    logic [FRAME_W-1:0] new_frame;
    logic               present_bit;
    logic               rw_bit;
    logic               user_bit;
    logic               no_free_frame;
  } res_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } enc_t;

  function automatic enc_t lowest_one(input logic [WORD_BITS-1:0] v);
    enc_t r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/frame_bitmap_allocator.sv =====
// First-fit frame allocator: used bits in a word RAM, full bits in a summary RAM.
// Requests are handled one at a time.
// Reset (rst_n, synchronous): frame_count returns to 4096 and a clearing pass writes
// zero to every bitmap word, with in_tready low meanwhile.
`include "frame_bitmap_allocator_defines.svh"

module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fba_pkg::CNT_W-1:0]      cfg_data,    // frame_count
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fba_pkg::IN_TDATA_W-1:0] in_tdata,    // current_frame, kernel_page, writable
  input  logic                           in_tuser,    // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // entry_written, new_frame, present_bit, rw_bit, user_bit, no_free_frame
  output logic [fba_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import fba_pkg::*;

  logic [CNT_W-1:0]       frame_count_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  req_t                   req;
  res_t                   res;
  logic                   res_valid, res_ready;

  assign req.kind          = in_tuser;
  assign req.current_frame = in_tdata[FRAME_W-1:0];
  assign req.kernel_page   = in_tdata[FRAME_W];
  assign req.writable      = in_tdata[FRAME_W+1];

  fba_core #(.NUM_FRAMES(NUM_FRAMES)) u_core (
    .clk(clk), .rst_n(rst_n), .frame_count(frame_count_r),
    .req_valid(in_tvalid), .req_ready(in_tready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_count_r <= cfg_data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      out_data_r <= {7'd0, res.no_free_frame, res.user_bit, res.rw_bit, res.present_bit,
                     res.new_frame, res.entry_written};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready,
                   !in_tready, "request accepted while busy")
  `FBA_ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid && res_ready,
                   out_tvalid, "result not registered")
  `FBA_ASSERT_NOW(a_full_clean, clk, rst_n, out_tvalid && out_tdata[16],
                  out_tdata[15:0] == 16'd0, "full result carries fields")
  `FBA_ASSERT_NOW(a_present_written, clk, rst_n, out_tvalid && out_tdata[13],
                  out_tdata[0], "present without entry write")

endmodule

// ===== rtl/fba_ram.sv =====
module fba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fba_core.sv =====
module fba_core #(
  parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [fba_pkg::CNT_W-1:0] frame_count,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  fba_pkg::req_t            req,
  output logic                     res_valid,
  input  logic                     res_ready,
  output fba_pkg::res_t            res
);
  import fba_pkg::*;

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_WORDS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SAW       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int FW        = WAW + BIT_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SUM, ST_MAP, ST_FREE, ST_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  logic [WAW-1:0]   clr_r, clr_nxt;
  logic [SAW-1:0]   s_r, s_nxt;
  logic [WAW-1:0]   w_r, w_nxt;
  req_t             req_r, req_nxt;
  res_t             res_r, res_nxt;

  logic                 map_we, map_re, sum_we, sum_re;
  logic [WAW-1:0]       map_waddr, map_raddr;
  logic [SAW-1:0]       sum_waddr, sum_raddr;
  logic [WORD_BITS-1:0] map_wdata, map_rdata, sum_wdata, sum_rdata;

  logic [CNT_W-1:0]     limit;
  logic [7:0]           lim_words;
  logic [31:0]          sum_base, sum_rem;
  logic [WORD_BITS-1:0] smask;
  enc_t                 senc, benc;
  logic [FW-1:0]        f;
  logic [WAW-1:0]       cur_w, found_w;
  logic                 more_sum;

  fba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS), .AW(WAW)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
  );

  fba_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_WORDS), .AW(SAW)) u_sum (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .re(sum_re), .raddr(sum_raddr), .rdata(sum_rdata)
  );

  always_comb begin
    limit     = (32'(frame_count) > NUM_FRAMES) ? CNT_W'(NUM_FRAMES) : frame_count;
    lim_words = 8'((32'(limit) + 32'(WORD_BITS - 1)) >> BIT_W);
    sum_base  = 32'(s_r) << BIT_W;
    sum_rem   = 32'(lim_words) - sum_base;
    if (32'(lim_words) <= sum_base) begin
      smask = '0;
    end else if (sum_rem >= 32'(WORD_BITS)) begin
      smask = '1;
    end else begin
      smask = ~({WORD_BITS{1'b1}} << sum_rem);
    end
    senc     = lowest_one(~sum_rdata & smask);
    benc     = lowest_one(~map_rdata);
    f        = {w_r, benc.idx};
    cur_w    = WAW'(req_r.current_frame >> BIT_W);
    found_w  = WAW'({s_r, senc.idx});
    more_sum = (32'(s_r) + 32'd1 < 32'(SUM_WORDS)) &&
               (sum_base + 32'(WORD_BITS) < 32'(lim_words));
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    s_nxt     = s_r;
    w_nxt     = w_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    map_we    = 1'b0;
    map_waddr = w_r;
    map_wdata = '0;
    map_re    = 1'b0;
    map_raddr = w_r;
    sum_we    = 1'b0;
    sum_waddr = s_r;
    sum_wdata = '0;
    sum_re    = 1'b0;
    sum_raddr = s_r;

    unique case (state_r)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        if (32'(clr_r) < 32'(SUM_WORDS)) begin
          sum_we    = 1'b1;
          sum_waddr = SAW'(clr_r);
        end
        if (clr_r == WAW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          req_nxt = req;
          res_nxt = '0;
          if (req.kind == KIND_ALLOC) begin
            if (req.current_frame != '0) begin
              state_nxt = ST_RESULT;
            end else begin
              s_nxt     = '0;
              sum_re    = 1'b1;
              sum_raddr = '0;
              state_nxt = ST_SUM;
            end
          end else begin
            if (req.current_frame == '0) begin
              state_nxt = ST_RESULT;
            end else begin
              res_nxt.entry_written = 1'b1;
              if (32'(req.current_frame) < 32'(NUM_FRAMES)) begin
                w_nxt     = WAW'(req.current_frame >> BIT_W);
                map_re    = 1'b1;
                map_raddr = WAW'(req.current_frame >> BIT_W);
                sum_re    = 1'b1;
                sum_raddr = SAW'(req.current_frame >> (2 * BIT_W));
                state_nxt = ST_FREE;
              end else begin
                state_nxt = ST_RESULT;
              end
            end
          end
        end
      end
      ST_SUM: begin
        if (senc.found) begin
          w_nxt     = found_w;
          map_re    = 1'b1;
          map_raddr = found_w;
          state_nxt = ST_MAP;
        end else if (more_sum) begin
          s_nxt     = SAW'(s_r + 1'b1);
          sum_re    = 1'b1;
          sum_raddr = SAW'(s_r + 1'b1);
        end else begin
          res_nxt.no_free_frame = 1'b1;
          state_nxt             = ST_RESULT;
        end
      end
      ST_MAP: begin
        if (benc.found && (32'(f) < 32'(limit))) begin
          map_we    = 1'b1;
          map_waddr = w_r;
          map_wdata = map_rdata | (WORD_BITS'(1) << benc.idx);
          if (map_wdata == '1) begin
            sum_we    = 1'b1;
            sum_waddr = s_r;
            sum_wdata = sum_rdata | (WORD_BITS'(1) << BIT_W'(w_r));
          end
          res_nxt.entry_written = 1'b1;
          res_nxt.new_frame     = FRAME_W'(f);
          res_nxt.present_bit   = 1'b1;
          res_nxt.rw_bit        = req_r.writable;
          res_nxt.user_bit      = ~req_r.kernel_page;
        end else begin
          res_nxt.no_free_frame = 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_FREE: begin
        map_we    = 1'b1;
        map_waddr = cur_w;
        map_wdata = map_rdata & ~(WORD_BITS'(1) << req_r.current_frame[BIT_W-1:0]);
        sum_we    = 1'b1;
        sum_waddr = SAW'(cur_w >> BIT_W);
        sum_wdata = sum_rdata & ~(WORD_BITS'(1) << BIT_W'(cur_w));
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    s_r   <= s_nxt;
    w_r   <= w_nxt;
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESULT);
  assign res       = res_r;

endmodule

// ===== test/tb_frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator;
  import fba_pkg::*;

  localparam int MAP_FRAMES  = NUM_FRAMES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    bit               kind;
    bit [FRAME_W-1:0] current_frame;
    bit               kernel_page;
    bit               writable;
  } page_req_t;

  typedef struct {
    bit               entry_written;
    bit [FRAME_W-1:0] new_frame;
    bit               present_bit;
    bit               rw_bit;
    bit               user_bit;
    bit               no_free_frame;
  } page_entry_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // current_frame, kernel_page, writable
  logic                   in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // entry_written, new_frame, present_bit, rw_bit, user_bit, no_free_frame
  logic [OUT_TDATA_W-1:0] out_tdata;

  bit [MAP_FRAMES-1:0] used_frames;
  int unsigned         frame_limit;
  page_entry_t         pending_entries[$];
  page_entry_t         want_entry;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  bit sender_gaps = 1'b0;
  int burst_left = 0;

  bit rx_stalls = 1'b0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int run_left = 0;
  bit run_ready = 1'b1;

  frame_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // first-fit allocation and freeing over the frame bitmap, applied per accepted request
  function automatic page_entry_t apply_request(input page_req_t req);
    page_entry_t res;
    int          lim;
    int          f;
    res = '{default: 0};
    if (req.kind == KIND_ALLOC) begin
      if (req.current_frame != 0) return res;
      lim = (frame_limit > MAP_FRAMES) ? MAP_FRAMES : int'(frame_limit);
      for (f = 0; f < lim; f++) begin
        if (!used_frames[f]) break;
      end
      if (f < lim) begin
        used_frames[f]    = 1'b1;
        res.entry_written = 1'b1;
        res.new_frame     = f[FRAME_W-1:0];
        res.present_bit   = 1'b1;
        res.rw_bit        = req.writable;
        res.user_bit      = ~req.kernel_page;
      end else begin
        res.no_free_frame = 1'b1;
      end
    end else if (req.current_frame != 0) begin
      used_frames[req.current_frame] = 1'b0;
      res.entry_written = 1'b1;
    end
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_entries.size() == 0) begin
        $error("result transaction with nothing pending: %h", out_tdata);
        mismatches++;
      end else begin
        want_entry = pending_entries.pop_front();
        check_field("entry_written", want_entry.entry_written, out_tdata[0]);
        check_field("new_frame", want_entry.new_frame, out_tdata[12:1]);
        check_field("present_bit", want_entry.present_bit, out_tdata[13]);
        check_field("rw_bit", want_entry.rw_bit, out_tdata[14]);
        check_field("user_bit", want_entry.user_bit, out_tdata[15]);
        check_field("no_free_frame", want_entry.no_free_frame, out_tdata[16]);
      end
    end
  end

  // result side: long hold-off on request, else always ready or, with rx_stalls, random ready/stall runs
  always @(negedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (!rx_stalls) begin
      out_tready = 1'b1;
    end else begin
      if (run_left == 0) begin
        run_ready = ($urandom_range(0, 2) != 0);
        run_left  = $urandom_range(1, 9);
      end
      run_left--;
      out_tready = run_ready;
    end
  end

  task automatic send_request(input bit kind, input int unsigned cur, input bit kern,
                              input bit wr);
    page_req_t req;
    int        gap;
    req.kind          = kind;
    req.current_frame = cur[FRAME_W-1:0];
    req.kernel_page   = kern;
    req.writable      = wr;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {2'b00, wr, kern, req.current_frame};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_entries.push_back(apply_request(req));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_count(input int unsigned count);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = count[CNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    frame_limit = count;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_alloc_and_free();
    send_request(KIND_ALLOC, 0, 1'b0, 1'b0);
    send_request(KIND_ALLOC, 0, 1'b1, 1'b1);
    send_request(KIND_ALLOC, 0, 1'b0, 1'b1);
    send_request(KIND_ALLOC, 0, 1'b1, 1'b0);
    // already mapped
    send_request(KIND_ALLOC, 4095, 1'b1, 1'b1);
    send_request(KIND_ALLOC, 1, 1'b0, 1'b0);
    // frame zero cannot be freed
    send_request(KIND_FREE, 0, 1'b1, 1'b1);
    send_request(KIND_FREE, 1, 1'b0, 1'b0);
    send_request(KIND_ALLOC, 0, 1'b0, 1'b1);
    send_request(KIND_FREE, 4095, 1'b1, 1'b0);
    send_request(KIND_FREE, 2, 1'b0, 1'b1);
    send_request(KIND_FREE, 2, 1'b1, 1'b1);
    send_request(KIND_ALLOC, 0, 1'b1, 1'b1);
  endtask

  task automatic test_frame_count_limits();
    set_frame_count(0);
    send_request(KIND_ALLOC, 0, 1'b0, 1'b1);
    send_request(KIND_ALLOC, 0, 1'b1, 1'b0);
    set_frame_count(8191);
    send_request(KIND_ALLOC, 0, 1'b0, 1'b0);
    set_frame_count(1);
    send_request(KIND_ALLOC, 0, 1'b1, 1'b1);
    set_frame_count(2);
    send_request(KIND_FREE, 1, 1'b0, 1'b0);
    send_request(KIND_ALLOC, 0, 1'b0, 1'b1);
    send_request(KIND_ALLOC, 0, 1'b1, 1'b1);
    // frame above the managed count is still released
    send_request(KIND_FREE, 4, 1'b1, 1'b0);
    set_frame_count(6);
    send_request(KIND_ALLOC, 0, 1'b0, 1'b0);
    send_request(KIND_ALLOC, 0, 1'b1, 1'b0);
    send_request(KIND_ALLOC, 0, 1'b0, 1'b1);
    set_frame_count(MAP_FRAMES);
  endtask

  task automatic test_backpressure();
    int n;
    rx_stalls   = 1'b0;
    sender_gaps = 1'b0;
    set_frame_count(96);
    stall_req++;
    for (n = 0; n < 24; n++) begin
      send_request((n % 3 == 2) ? KIND_FREE : KIND_ALLOC,
                   (n % 3 == 2) ? $urandom_range(1, 40) : 0,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    drain_results();
    sender_gaps = 1'b1;
    for (n = 0; n < 10; n++) begin
      send_request(KIND_ALLOC, 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          n;
    int          alloc_pct;
    int          pick;
    int unsigned count;
    int unsigned cur;
    bit          kind;
    for (phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = MAP_FRAMES;
        2:       count = 8191;
        3:       count = $urandom_range(MAP_FRAMES + 1, 8191);
        default: count = $urandom_range(1, 260);
      endcase
      set_frame_count(count);
      rx_stalls   = ($urandom_range(0, 3) != 0);
      sender_gaps = ($urandom_range(0, 3) != 0);
      alloc_pct   = $urandom_range(35, 85);
      for (n = 0; n < 60; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
          kind = KIND_ALLOC;
          cur  = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4095) : 0;
        end else begin
          kind = KIND_FREE;
          pick = $urandom_range(0, 9);
          if (pick == 0) cur = 0;
          else if (pick < 3) cur = $urandom_range(0, 4095);
          else cur = $urandom_range(1, 300);
        end
        send_request(kind, cur, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = KIND_ALLOC;
    used_frames = '0;
    frame_limit = MAP_FRAMES;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_alloc_and_free();
    test_frame_count_limits();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fba_pkg.sv
rtl/fba_ram.sv
rtl/fba_core.sv
rtl/frame_bitmap_allocator.sv
test/tb_frame_bitmap_allocator.sv
